FILE: hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 8;
    localparam int COUNT_BITS   = 5;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } spq_req_t;

    typedef struct packed {
        logic                    removed_valid;
        logic [KEY_BITS-1:0]     removed_key;
        logic [PAYLOAD_BITS-1:0] removed_payload;
        logic                    overflow;
        logic                    is_empty;
        logic [KEY_BITS-1:0]     head_key;
        logic [COUNT_BITS-1:0]   entry_count;
    } spq_res_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;   // capture the incoming request
        logic exec;    // apply the held request and load the result register
    } spq_cmd_t;

endpackage

FILE: hdl/spq_ctrl.sv
// Controller: request handshake, sequencing and result valid.
module spq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            res_valid,
    input  logic            res_stall,
    output spq_pkg::spq_cmd_t cmd
);
    import spq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic res_valid_reg, res_valid_next;
    logic accept;
    logic exec;

    // Handshake: one request held at a time
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign exec      = (state_reg == ST_EXEC) && (!res_valid_reg || !res_stall);

    assign cmd.latch = accept;
    assign cmd.exec  = exec;
    assign res_valid = res_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result valid: set on execution, cleared when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        priority if (exec)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

FILE: hdl/spq_dp.sv
// Datapath: sorted row of entry cells, request and result registers.
module spq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  spq_pkg::spq_cmd_t cmd,
    input  spq_pkg::spq_req_t req,
    output spq_pkg::spq_res_t res
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_req_t                req_reg;
    spq_res_t                res_reg, res_next;
    logic [KEY_BITS-1:0]     keys_reg [CAPACITY];
    logic [KEY_BITS-1:0]     keys_next [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pays_reg [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pays_next [CAPACITY];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CAPACITY-1:0]     le;
    logic                    full;
    logic                    prev_le;

    assign full = (count_reg == CNT_W'(CAPACITY));
    assign res  = res_reg;

    // Per-cell compare: occupied and key <= new key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            le[i] = (CNT_W'(i) < count_reg) && (keys_reg[i] <= req_reg.key);
    end

    // Cell update and result
    always_comb
    begin
        prev_le    = 1'b1;
        count_next = count_reg;
        res_next   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            keys_next[i] = keys_reg[i];
            pays_next[i] = pays_reg[i];
        end

        unique case (req_reg.op)
            OP_INSERT:
            begin
                if (full)
                    res_next.overflow = 1'b1;
                else
                begin
                    // A cell keeps its entry, takes the new one, or takes its left neighbor
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (i == 0)
                            prev_le = 1'b1;
                        else
                            prev_le = le[i-1];
                        if (!le[i])
                        begin
                            if (prev_le)
                            begin
                                keys_next[i] = req_reg.key;
                                pays_next[i] = req_reg.payload;
                            end
                            else
                            begin
                                keys_next[i] = keys_reg[i-1];
                                pays_next[i] = pays_reg[i-1];
                            end
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (count_reg != '0)
                begin
                    res_next.removed_valid   = 1'b1;
                    res_next.removed_key     = keys_reg[0];
                    res_next.removed_payload = pays_reg[0];
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        keys_next[i] = keys_reg[i+1];
                        pays_next[i] = pays_reg[i+1];
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase

        // Status after the step
        res_next.is_empty    = (count_next == '0);
        res_next.head_key    = (count_next == '0) ? '0 : keys_next[0];
        res_next.entry_count = COUNT_BITS'(count_next);
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    // Entry cells, request and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            req_reg <= req;
        if (cmd.exec)
        begin
            res_reg <= res_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                keys_reg[i] <= keys_next[i];
                pays_reg[i] <= pays_next[i];
            end
        end
    end

endmodule

FILE: hdl/stable_priority_queue_top.sv
// Stable priority queue: an accepted request is latched, then executed once the output
// register is free, and its result registered; a new request is taken only after the
// held one has executed. An insert shifts the cells behind its place, a remove the whole
// row. A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, asynchronous) empties the queue; entry contents are not cleared.
module stable_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  spq_pkg::spq_req_t req,
    output logic              res_valid,
    input  logic              res_stall,
    output spq_pkg::spq_res_t res
);
    import spq_pkg::*;

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .res   (res)
    );

endmodule

FILE: tb/spq_checker.sv
// Scoreboard for the stable priority queue: predicts each result from the accepted requests.
module spq_checker #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  spq_pkg::spq_req_t req,
    input  logic              res_valid,
    input  logic              res_stall,
    input  spq_pkg::spq_res_t res,
    output int                error_count,
    output int                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // Shadow copy of the sorted entry row
    logic [KEY_BITS-1:0]     queued_keys     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] queued_payloads [CAPACITY];
    int                      queued_count;

    spq_res_t expected_results [$];
    int       failures = 0;
    int       outstanding;

    assign error_count   = failures;
    assign pending_count = outstanding;

    // Apply one request to the shadow queue and return the result it should produce
    function automatic spq_res_t apply_request(input spq_req_t r);
        spq_res_t o;
        int       pos;
        int       i;
        o = '0;
        if (r.op == OP_INSERT)
        begin
            if (queued_count >= CAPACITY)
            begin
                o.overflow = 1'b1;
            end
            else
            begin
                // new entry goes behind every key <= its own (keeps ties in arrival order)
                pos = 0;
                while (pos < queued_count && queued_keys[pos] <= r.key)
                    pos++;
                for (i = queued_count; i > pos; i--)
                begin
                    queued_keys[i]     = queued_keys[i-1];
                    queued_payloads[i] = queued_payloads[i-1];
                end
                queued_keys[pos]     = r.key;
                queued_payloads[pos] = r.payload;
                queued_count++;
            end
        end
        else if (queued_count > 0)
        begin
            o.removed_valid   = 1'b1;
            o.removed_key     = queued_keys[0];
            o.removed_payload = queued_payloads[0];
            for (i = 1; i < queued_count; i++)
            begin
                queued_keys[i-1]     = queued_keys[i];
                queued_payloads[i-1] = queued_payloads[i];
            end
            queued_count--;
        end
        o.is_empty    = (queued_count == 0);
        o.head_key    = (queued_count == 0) ? '0 : queued_keys[0];
        o.entry_count = queued_count[COUNT_BITS-1:0];
        return o;
    endfunction

    // Field-by-field compare of one result; returns the number of bad fields
    function automatic int compare_result(input spq_res_t exp_r, input spq_res_t act_r);
        int bad;
        bad = 0;
        if (act_r.removed_valid !== exp_r.removed_valid)
        begin
            $error("removed_valid: expected %0h, got %0h", exp_r.removed_valid,
                   act_r.removed_valid);
            bad++;
        end
        if (act_r.removed_key !== exp_r.removed_key)
        begin
            $error("removed_key: expected %0h, got %0h", exp_r.removed_key, act_r.removed_key);
            bad++;
        end
        if (act_r.removed_payload !== exp_r.removed_payload)
        begin
            $error("removed_payload: expected %0h, got %0h", exp_r.removed_payload,
                   act_r.removed_payload);
            bad++;
        end
        if (act_r.overflow !== exp_r.overflow)
        begin
            $error("overflow: expected %0h, got %0h", exp_r.overflow, act_r.overflow);
            bad++;
        end
        if (act_r.is_empty !== exp_r.is_empty)
        begin
            $error("is_empty: expected %0h, got %0h", exp_r.is_empty, act_r.is_empty);
            bad++;
        end
        if (act_r.head_key !== exp_r.head_key)
        begin
            $error("head_key: expected %0h, got %0h", exp_r.head_key, act_r.head_key);
            bad++;
        end
        if (act_r.entry_count !== exp_r.entry_count)
        begin
            $error("entry_count: expected %0d, got %0d", exp_r.entry_count, act_r.entry_count);
            bad++;
        end
        return bad;
    endfunction

    // Watch both channels; a request is predicted before a result is popped
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_count = 0;
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_results.push_back(apply_request(req));
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result accepted with no request outstanding");
                    failures++;
                end
                else
                begin
                    failures += compare_result(expected_results[0], res);
                    void'(expected_results.pop_front());
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

FILE: tb/stable_priority_queue_top_tb.sv
// Stimulus, flow control and verdict for the stable priority queue testbench.
module stable_priority_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1900;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {KEYS_ANY, KEYS_TIED, KEYS_EXTREME} key_mix_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    spq_req_t req;
    logic     res_valid;
    logic     res_stall;
    spq_res_t res;

    int error_count;
    int pending_count;
    int quiet_cycles;

    stable_priority_queue_top #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    spq_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res           (res),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Offer one request and hold it until it is taken
    task automatic offer(input spq_req_t r);
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Sender gap
    task automatic pause(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic spq_req_t make_request(input logic [KEY_BITS-1:0] k,
                                              input logic [PAYLOAD_BITS-1:0] p,
                                              input logic o);
        spq_req_t r;
        r.op      = o;
        r.key     = k;
        r.payload = p;
        return r;
    endfunction

    // Random request; insert_pct biases toward filling or draining
    function automatic spq_req_t random_request(input int insert_pct, input key_mix_t mix);
        spq_req_t r;
        r.op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        case (mix)
            KEYS_TIED:    r.key = KEY_BITS'($urandom_range(7));
            KEYS_EXTREME: r.key = ($urandom_range(1) != 0) ? {KEY_BITS{1'b1}}
                                                           : KEY_BITS'($urandom_range(1));
            default:      r.key = KEY_BITS'($urandom);
        endcase
        r.payload = PAYLOAD_BITS'($urandom);
        return r;
    endfunction

    // Receiver stall pattern, with a long hold-off every twelfth phase
    initial
    begin
        int phase;
        int span;
        int mode;
        res_stall <= 1'b0;
        phase = 0;
        forever
        begin
            if (phase % 12 == 2)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(60, 120)) @(posedge clk);
            end
            else
            begin
                span = $urandom_range(10, 80);
                mode = $urandom_range(2);
                repeat (span)
                begin
                    case (mode)
                        0:       res_stall <= 1'b0;
                        1:       res_stall <= ($urandom_range(2) == 0);
                        default: res_stall <= ($urandom_range(3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
            phase++;
        end
    end

    // Count cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence: reset, directed requests, random bursts, drain, verdict
    initial
    begin
        int       sent;
        int       burst;
        int       insert_pct;
        key_mix_t mix;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // remove from empty, key/payload extremes, equal keys leave in arrival order
        offer(make_request('0, '0, OP_REMOVE));
        offer(make_request(16'hFFFF, 8'h00, OP_INSERT));
        offer(make_request(16'h0000, 8'hFF, OP_INSERT));
        offer(make_request(16'h8000, 8'h11, OP_INSERT));
        offer(make_request(16'h8000, 8'h22, OP_INSERT));
        offer(make_request(16'h0000, 8'h01, OP_INSERT));
        offer(make_request(16'hAAAA, 8'h55, OP_INSERT));
        offer(make_request(16'h5555, 8'hAA, OP_INSERT));
        repeat (7) offer(make_request(16'hFFFF, 8'hFF, OP_REMOVE));
        offer(make_request(16'h1234, 8'h5A, OP_REMOVE));

        // random bursts; fill phases push the queue into overflow, drain phases empty it
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(2))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            mix   = key_mix_t'($urandom_range(2));
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                offer(random_request(insert_pct, mix));
                sent++;
            end
            if ($urandom_range(2) != 0)
                pause($urandom_range(1, 6));
        end
        req_valid <= 1'b0;

        // let the scoreboard record the last accepted request before draining
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_dp.sv
hdl/stable_priority_queue_top.sv
tb/spq_checker.sv
tb/stable_priority_queue_top_tb.sv
